// ===== rtl/point_in_polygon_test_assert.svh =====
// Assertion macros shared by the point-in-polygon RTL.
// Included by the top level; depends on nothing else.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define PIP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define PIP_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// Shared types and widths for the point-in-polygon test.
// No dependencies; used by the interfaces, the edge unit and the top level.
`default_nettype none

package pip_pkg;

  // Coordinate width, signed Q16.16.
  localparam int COORD_WIDTH = 32;
  // A difference of two coordinates needs one more bit.
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // Full product of two differences.
  localparam int PROD_W      = 2 * DIFF_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Products of one edge's crossing test; the edge toggles the parity
  // when it straddles the query's y and lhs is below rhs.
  typedef struct packed {
    logic  straddle;
    prod_t lhs;
    prod_t rhs;
  } edge_prod_t;

endpackage

`default_nettype wire

// ===== rtl/pip_if.sv =====
// Stream interfaces of the point-in-polygon test: vertex input and result output.
// Depends on pip_pkg.
`default_nettype none

interface pip_vertex_if;
  logic            valid;
  logic            ready;
  pip_pkg::coord_t vertex_x;
  pip_pkg::coord_t vertex_y;
  pip_pkg::coord_t query_x;
  pip_pkg::coord_t query_y;
  logic            first_vertex;
  logic            last_vertex;

  modport source (
    output valid, vertex_x, vertex_y, query_x, query_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_x, vertex_y, query_x, query_y, first_vertex, last_vertex,
    output ready
  );
endinterface

interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
// Top level of the streaming even-odd point-in-polygon test.
// Depends on pip_pkg, pip_if.sv, pip_edge_prod and point_in_polygon_test_assert.svh.
`default_nettype none

`include "point_in_polygon_test_assert.svh"

// Even-odd ray-casting test over a stream of polygon vertices. Each beat on
// vtx_i carries one vertex; the beat marked first_vertex starts a polygon and
// also supplies the query point, which is held for the rest of the polygon.
// Every vertex after the first closes the edge from the previous vertex, and
// the vertex marked last_vertex also closes the edge back to the first one.
// An edge flips the crossing parity when it straddles the query's y and the
// query lies strictly left of the crossing; the crossing test is an exact
// cross-multiplication of signed Q16.16 values, so no rounding occurs. The
// last vertex emits one beat on res_o with inside_res set when the parity is
// odd, and clears the parity. A polygon of one or two vertices reads as
// outside. Vertices sent before any first mark continue from a start vertex,
// previous vertex and query point at the origin.
// Rate: one vertex per clock cycle while res_o takes results as they come. A
// last vertex is accepted into the input register, its products enter the
// product register behind the four 33x33 multipliers, and the result register
// then loads and presents the result beat. The start, previous-vertex and
// query registers and the parity register carry state from one vertex to the
// next. The result register is a separate stage, so vertices keep flowing
// while a result waits to be taken, until another last vertex reaches the
// product register; the input stalls once the input register behind it is
// occupied as well.
module point_in_polygon_test (
  input  wire              clk_i,
  input  wire              rst_ni,
  pip_vertex_if.sink       vtx_i,
  pip_result_if.source     res_o
);

  // Polygon context, updated as each vertex is accepted.
  pip_pkg::point_t start_q, prev_q, query_q;
  pip_pkg::point_t start_d, query_d, vtx_pt;

  // Stage 1: the vertex together with the context it is tested against.
  logic            s1_valid_q, s1_first_q, s1_last_q;
  pip_pkg::point_t s1_cur_q, s1_prev_q, s1_start_q, s1_query_q;

  // Stage 2: crossing products of the running edge and the closing edge.
  logic                s2_valid_q, s2_first_q, s2_last_q;
  pip_pkg::edge_prod_t s2_edge_a_q, s2_edge_b_q;
  pip_pkg::edge_prod_t edge_a, edge_b;

  // Parity and result register.
  logic parity_q, parity_run, toggle_a, toggle_b;
  logic res_valid_q, res_inside_q;

  logic vtx_acc, out_free, s2_go, s2_ready, s1_ready;

  // Backpressure: a stage moves when the one behind it has room.
  assign out_free = !res_valid_q || res_o.ready;
  assign s2_go    = s2_valid_q && (!s2_last_q || out_free);
  assign s2_ready = !s2_valid_q || s2_go;
  assign s1_ready = !s1_valid_q || s2_ready;

  assign vtx_i.ready = s1_ready;
  assign vtx_acc     = vtx_i.valid && s1_ready;

  assign vtx_pt.x = vtx_i.vertex_x;
  assign vtx_pt.y = vtx_i.vertex_y;

  // A first vertex replaces the start vertex and the query point.
  always_comb begin
    start_d = start_q;
    query_d = query_q;
    if (vtx_i.first_vertex) begin
      start_d   = vtx_pt;
      query_d.x = vtx_i.query_x;
      query_d.y = vtx_i.query_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      prev_q  <= '0;
      query_q <= '0;
    end else if (vtx_acc) begin
      start_q <= start_d;
      prev_q  <= vtx_pt;
      query_q <= query_d;
    end
  end

  // Stage 1 register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= vtx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_acc) begin
      s1_cur_q   <= vtx_pt;
      s1_prev_q  <= prev_q;
      s1_start_q <= start_d;
      s1_query_q <= query_d;
      s1_first_q <= vtx_i.first_vertex;
      s1_last_q  <= vtx_i.last_vertex;
    end
  end

  // The running edge goes from the previous vertex to this one; the
  // closing edge goes from the start vertex to this one.
  pip_edge_prod u_edge_run (
    .c_i    (s1_cur_q),
    .p_i    (s1_prev_q),
    .q_i    (s1_query_q),
    .edge_o (edge_a)
  );

  pip_edge_prod u_edge_close (
    .c_i    (s1_start_q),
    .p_i    (s1_cur_q),
    .q_i    (s1_query_q),
    .edge_o (edge_b)
  );

  // Stage 2 register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_edge_a_q <= edge_a;
      s2_edge_b_q <= edge_b;
      s2_first_q  <= s1_first_q;
      s2_last_q   <= s1_last_q;
    end
  end

  // A first vertex closes no running edge and starts from even parity.
  assign toggle_a   = !s2_first_q && s2_edge_a_q.straddle &&
                      (s2_edge_a_q.lhs < s2_edge_a_q.rhs);
  assign toggle_b   = s2_edge_b_q.straddle && (s2_edge_b_q.lhs < s2_edge_b_q.rhs);
  assign parity_run = s2_first_q ? 1'b0 : (parity_q ^ toggle_a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
    end else if (s2_go) begin
      parity_q <= s2_last_q ? 1'b0 : parity_run;
    end
  end

  // Result register: loads on a last vertex, empties when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s2_valid_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_last_q) begin
      res_inside_q <= parity_run ^ toggle_b;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.inside_res = res_inside_q;

  // A vertex is taken into a full input stage only when that stage drains.
  `PIP_NEVER(a_s1_overrun, clk_i, rst_ni, vtx_acc && s1_valid_q && !s2_ready,
             "vertex accepted over a stalled input stage")
  // The parity is even again once a polygon's result has left stage 2.
  `PIP_ASSERT(a_parity_cleared, clk_i, rst_ni, (s2_go && s2_last_q) |=> !parity_q,
              "parity not cleared after a result")
  // A first vertex becomes the start vertex of the polygon.
  `PIP_ASSERT(a_start_capture, clk_i, rst_ni,
              (vtx_acc && vtx_i.first_vertex) |=>
              (start_q.x == $past(vtx_i.vertex_x)) && (start_q.y == $past(vtx_i.vertex_y)),
              "start vertex not captured on a first vertex")

endmodule

`default_nettype wire

// ===== rtl/pip_edge_prod.sv =====
// Crossing products of one polygon edge against the query point.
// Depends on pip_pkg.
`default_nettype none

module pip_edge_prod (
  input  pip_pkg::point_t     c_i,
  input  pip_pkg::point_t     p_i,
  input  pip_pkg::point_t     q_i,
  output pip_pkg::edge_prod_t edge_o
);

  pip_pkg::diff_t cx, cy, px, py, qx, qy;
  pip_pkg::diff_t dy, fx, d_abs, fx_adj, qcx, qcy;
  logic           flip;

  assign cx = {c_i.x[pip_pkg::COORD_WIDTH-1], c_i.x};
  assign cy = {c_i.y[pip_pkg::COORD_WIDTH-1], c_i.y};
  assign px = {p_i.x[pip_pkg::COORD_WIDTH-1], p_i.x};
  assign py = {p_i.y[pip_pkg::COORD_WIDTH-1], p_i.y};
  assign qx = {q_i.x[pip_pkg::COORD_WIDTH-1], q_i.x};
  assign qy = {q_i.y[pip_pkg::COORD_WIDTH-1], q_i.y};

  assign dy   = py - cy;
  assign fx   = px - cx;
  assign qcx  = qx - cx;
  assign qcy  = qy - cy;

  // Fold the sign of the y span into the x span so the scaled compare
  // keeps its direction.
  assign flip   = dy[pip_pkg::DIFF_W-1];
  assign d_abs  = flip ? -dy : dy;
  assign fx_adj = flip ? -fx : fx;

  assign edge_o.straddle = (c_i.y > q_i.y) != (p_i.y > q_i.y);
  assign edge_o.lhs      = pip_pkg::prod_t'(qcx) * pip_pkg::prod_t'(d_abs);
  assign edge_o.rhs      = pip_pkg::prod_t'(fx_adj) * pip_pkg::prod_t'(qcy);

endmodule

`default_nettype wire
